>>> rtl/core/tip_pkg.sv
package tip_pkg;

  localparam int COORD_BITS = 16;

  // coordinate difference, cross/square product, cross term, squared norm
  localparam int DIF_W = COORD_BITS + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int CRS_W = PRD_W + 1;
  localparam int NRM_W = PRD_W;

  // norm split into two halves for the determinant products
  localparam int NLO_W = NRM_W / 2;
  localparam int NHI_W = NRM_W - NLO_W;
  localparam int PPL_W = CRS_W + NLO_W + 1;
  localparam int PPH_W = CRS_W + NHI_W + 1;

  localparam int TRM_W = CRS_W + NRM_W;
  localparam int SUM_W = TRM_W + 2;

  localparam int NUM_STG = 6;

  localparam logic [1:0] POS_OUTSIDE  = 2'd0;
  localparam logic [1:0] POS_BOUNDARY = 2'd1;
  localparam logic [1:0] POS_INSIDE   = 2'd2;

  typedef struct packed {
    logic [NUM_STG-1:0] load;
  } tip_ctrl_t;

endpackage

>>> rtl/core/tip_if.sv
interface tip_in_if import tip_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] qx;
  logic signed [COORD_BITS-1:0] qy;

  modport source (output valid, ax, ay, bx, by, cx, cy, qx, qy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, qx, qy, output ready);
endinterface

interface tip_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] position;
  logic       in_circle;

  modport source (output valid, position, in_circle, input ready);
  modport sink   (input valid, position, in_circle, output ready);
endinterface

>>> rtl/core/triangle_incircle_predicates_unit.sv
// Triangle point location and Delaunay incircle predicates.
// in_bus carries one triangle (ax..cy) and a query point (qx, qy) per beat;
// out_bus returns one beat per input beat, in order: position (0 outside,
// 1 on an edge but not at a vertex, 2 inside, counter-clockwise triangles only) and in_circle.
// Both channels use valid/ready; a beat moves when both are high.
// Six register stages: differences, products, cross terms and norms,
// split determinant products, determinant terms, output register.
// Throughput is one beat per cycle while out_ready is high; every
// stage has its own valid bit and loads whenever it is empty or drains,
// so bubbles close up under a stall. When the receiver holds ready low
// the output beat stays put and stages fill behind it; in_ready falls
// only once all six stages are full. The slowest stage is the signed
// 35 x 18 bit multiply of the split incircle products.
// Reset (rst_n low at a clock edge) empties the pipeline; no other state.
module triangle_incircle_predicates_unit import tip_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  tip_in_if.sink  in_bus,
  tip_out_if.source out_bus
);

  tip_ctrl_t ctrl;

  tip_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .ctrl      (ctrl)
  );

  // stage 1: offsets from the query point
  logic signed [DIF_W-1:0] dax_r, day_r, dbx_r, dby_r, dcx_r, dcy_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      dax_r <= DIF_W'(in_bus.ax) - DIF_W'(in_bus.qx);
      day_r <= DIF_W'(in_bus.ay) - DIF_W'(in_bus.qy);
      dbx_r <= DIF_W'(in_bus.bx) - DIF_W'(in_bus.qx);
      dby_r <= DIF_W'(in_bus.by) - DIF_W'(in_bus.qy);
      dcx_r <= DIF_W'(in_bus.cx) - DIF_W'(in_bus.qx);
      dcy_r <= DIF_W'(in_bus.cy) - DIF_W'(in_bus.qy);
    end
  end

  // stage 2: cross products and squares
  logic signed [PRD_W-1:0] p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r;
  logic        [PRD_W-1:0] sqax_r, sqay_r, sqbx_r, sqby_r, sqcx_r, sqcy_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      p1a_r  <= dax_r * dby_r;
      p1b_r  <= dbx_r * day_r;
      p2a_r  <= dbx_r * dcy_r;
      p2b_r  <= dby_r * dcx_r;
      p3a_r  <= dcx_r * day_r;
      p3b_r  <= dcy_r * dax_r;
      sqax_r <= dax_r * dax_r;
      sqay_r <= day_r * day_r;
      sqbx_r <= dbx_r * dbx_r;
      sqby_r <= dby_r * dby_r;
      sqcx_r <= dcx_r * dcx_r;
      sqcy_r <= dcy_r * dcy_r;
    end
  end

  // stage 3: orientation cross terms and squared norms
  logic signed [CRS_W-1:0] c1_r, c2_r, c3_r;
  logic        [NRM_W-1:0] na_r, nb_r, nc_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      c1_r <= CRS_W'(p1a_r) - CRS_W'(p1b_r);
      c2_r <= CRS_W'(p2a_r) - CRS_W'(p2b_r);
      c3_r <= CRS_W'(p3a_r) - CRS_W'(p3b_r);
      na_r <= sqax_r + sqay_r;
      nb_r <= sqbx_r + sqby_r;
      nc_r <= sqcx_r + sqcy_r;
    end
  end

  // stage 4: orientation sum class, split determinant products
  logic [1:0] npos, nneg;
  logic [1:0] pos_nxt;
  logic       force_nxt, use_det_nxt;

  always_comb begin
    npos = {1'b0, (c1_r > 0)} + {1'b0, (c2_r > 0)} + {1'b0, (c3_r > 0)};
    nneg = {1'b0, c1_r[CRS_W-1]} + {1'b0, c2_r[CRS_W-1]} + {1'b0, c3_r[CRS_W-1]};
    pos_nxt = POS_OUTSIDE;
    if (npos == 2'd3) begin
      pos_nxt = POS_INSIDE;
    end else if (npos == 2'd2 && nneg == 2'd0) begin
      pos_nxt = POS_BOUNDARY;
    end
    force_nxt   = (npos == 2'd3) || (npos == 2'd2 && nneg == 2'd0);
    use_det_nxt = (npos == 2'd1 && nneg == 2'd0) || (npos == 2'd2 && nneg == 2'd1);
  end

  logic signed [PPL_W-1:0] pl1_r, pl2_r, pl3_r;
  logic signed [PPH_W-1:0] ph1_r, ph2_r, ph3_r;
  logic [1:0]              pos4_r;
  logic                    force4_r, usedet4_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      pl1_r     <= c1_r * $signed({1'b0, nc_r[NLO_W-1:0]});
      ph1_r     <= c1_r * $signed({1'b0, nc_r[NRM_W-1:NLO_W]});
      pl2_r     <= c2_r * $signed({1'b0, na_r[NLO_W-1:0]});
      ph2_r     <= c2_r * $signed({1'b0, na_r[NRM_W-1:NLO_W]});
      pl3_r     <= c3_r * $signed({1'b0, nb_r[NLO_W-1:0]});
      ph3_r     <= c3_r * $signed({1'b0, nb_r[NRM_W-1:NLO_W]});
      pos4_r    <= pos_nxt;
      force4_r  <= force_nxt;
      usedet4_r <= use_det_nxt;
    end
  end

  // stage 5: recombine halves into full determinant terms
  logic signed [TRM_W-1:0] t1_r, t2_r, t3_r;
  logic [1:0]              pos5_r;
  logic                    force5_r, usedet5_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      t1_r      <= (TRM_W'(ph1_r) <<< NLO_W) + TRM_W'(pl1_r);
      t2_r      <= (TRM_W'(ph2_r) <<< NLO_W) + TRM_W'(pl2_r);
      t3_r      <= (TRM_W'(ph3_r) <<< NLO_W) + TRM_W'(pl3_r);
      pos5_r    <= pos4_r;
      force5_r  <= force4_r;
      usedet5_r <= usedet4_r;
    end
  end

  // stage 6: determinant sign, output register
  logic signed [SUM_W-1:0] det;
  logic                    det_pos;
  logic [1:0]              pos_r;
  logic                    inc_r;

  always_comb begin
    det     = SUM_W'(t1_r) + SUM_W'(t2_r) + SUM_W'(t3_r);
    det_pos = !det[SUM_W-1] && (det != '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      pos_r <= pos5_r;
      inc_r <= force5_r || (usedet5_r && det_pos);
    end
  end

  assign out_bus.position  = pos_r;
  assign out_bus.in_circle = inc_r;

endmodule

>>> rtl/core/tip_pipe_ctrl.sv
module tip_pipe_ctrl import tip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tip_ctrl_t ctrl
);

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] load;

  // a stage loads when empty or when its contents move on
  always_comb begin
    load[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load[0]) vld_nxt[0] = in_valid;
    for (int k = 1; k < NUM_STG; k++) begin
      if (load[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld_r[NUM_STG-1];
  assign ctrl.load = load;

endmodule

>>> rtl/core/tip_chk.sv
module tip_chk import tip_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] position,
  input logic       in_circle
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without an output stall");

  a_pos_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> position != 2'd3)
    else $error("position code out of range");

  a_pos_circle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (position == POS_INSIDE || position == POS_BOUNDARY) |-> in_circle)
    else $error("point in or on triangle but not in circumcircle");

endmodule

bind triangle_incircle_predicates_unit tip_chk u_tip_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .position  (out_bus.position),
  .in_circle (out_bus.in_circle)
);
